[src/fpsa_pkg.sv]
// Shared types and codes for the free page stack allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package fpsa_pkg;

    // Request kinds.
    localparam logic [1:0] K_REGION = 2'd0;
    localparam logic [1:0] K_END    = 2'd1;
    localparam logic [1:0] K_ALLOC  = 2'd2;
    localparam logic [1:0] K_FREE   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NOMEM = 3'd1;
    localparam logic [2:0] ST_NULL  = 3'd2;
    localparam logic [2:0] ST_ALIGN = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] region_base;
        logic [24:0] region_length;
        logic        region_usable;
        logic [23:0] page_addr;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [23:0] alloc_addr;
        logic [24:0] total_bytes;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take the request into the datapath
        logic walk_push;  // push the current region page
        logic finish;     // apply the request and load the result register
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_kind;   // kind of the request at the input
        logic       walk_stop; // region walk has no more pages to push
        logic       out_free;  // result register can take a new result
    } t_ctl_stat;

endpackage

[src/free_page_stack_allocator_core.sv]
// Top level of the free page stack allocator.
// Depends on fpsa_pkg, fpsa_ctl, fpsa_dp (and fpsa_ram below it).
//
// The block keeps free page frames on a LIFO list: the head frame sits in a
// register and the link to the frame below each one sits in a RAM.
// Requests arrive on the input channel (i_in_valid, o_in_stall, i_in_data)
// and each one gives exactly one result on the output channel (o_out_valid,
// i_out_stall, o_out_data). A request is taken when valid is high and stall
// is low; requests are worked one at a time.
// End-of-regions, allocate and free are taken in the idle state, load the
// result register from the execute state once it can take a result, and
// the next request is then taken back in the idle state. Allocate reads the
// link RAM in the acceptance cycle and updates the head when its result is
// loaded. An add-region request first pushes its pages in the walk state,
// one link per cycle through the single RAM write port, then loads its result.
// A result waits in the output register while the receiver stalls; the
// block holds the finished request and takes no new one until the result
// register can be loaded again.
// Reset empties the list and clears the byte total; the link RAM is not
// cleared, because a link is only read after its frame was pushed.
module free_page_stack_allocator_core
    import fpsa_pkg::*;
#(
    parameter int PAGE_COUNT = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_ctl_cmd  cmd;
    t_ctl_stat stat;

    fpsa_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fpsa_dp #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[src/fpsa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fpsa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/fpsa_ctl.sv]
// Controller state machine of the free page stack allocator.
// Depends on fpsa_pkg; drives commands to fpsa_dp and reads its status.
module fpsa_ctl
    import fpsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_ctl_stat i_stat,
    output t_ctl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_stat.in_kind == K_REGION) ? S_WALK : S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WALK: begin
                if (i_stat.walk_stop) begin
                    if (i_stat.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.walk_push = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[src/fpsa_dp.sv]
// Datapath of the free page stack allocator: head register, byte total,
// region walk counters, next-link store and result register.
// Depends on fpsa_pkg and fpsa_ram; controlled by fpsa_ctl.
module fpsa_dp
    import fpsa_pkg::*;
#(
    parameter int PAGE_COUNT = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_ctl_cmd  i_cmd,
    output t_ctl_stat o_stat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int PB_W = $clog2(PAGE_BYTES);      // PAGE_BYTES is a power of two
    localparam int FW   = $clog2(PAGE_COUNT);      // store index width
    localparam int HW   = $clog2(PAGE_COUNT + 1);  // head and link width, holds empty
    localparam int FRW  = 26 - PB_W;               // region frame width
    localparam int CW   = ((FRW > HW) ? FRW : HW) + 1;

    localparam logic [CW-1:0] PC_C    = CW'(PAGE_COUNT);
    localparam logic [HW-1:0] EMPTY   = HW'(PAGE_COUNT);
    localparam logic [25:0]   PB_M1   = 26'(PAGE_BYTES - 1);
    localparam logic [25:0]   PB_26   = 26'(PAGE_BYTES);
    localparam logic [25:0]   TOT_MAX = 26'h1FFFFFF;

    logic [HW-1:0]  r_head;
    logic [24:0]    r_added;
    logic [1:0]     r_kind;
    logic [23:0]    r_page;
    logic [FRW-1:0] r_frame;
    logic [FRW-1:0] r_end;
    logic           r_out_valid;
    t_out_item      r_out;

    logic [25:0]    first_sum;
    logic [25:0]    end_sum;
    logic           head_empty;
    logic [HW-1:0]  link;
    logic [HW-1:0]  link_clip;
    logic [CW-1:0]  walk_frame;
    logic           walk_done;
    logic           walk_rng;
    logic [CW-1:0]  free_frame;
    logic [2:0]     free_status;
    logic [47:0]    head_bytes;
    logic [25:0]    added_inc;
    logic           out_free;
    logic           free_push;
    t_out_item      res;

    // Page-rounded start and exclusive end frame of the region.
    assign first_sum = 26'(i_in_data.region_base) + PB_M1;
    assign end_sum   = 26'(i_in_data.region_base) + 26'(i_in_data.region_length) + PB_M1;

    assign head_empty = (CW'(r_head) >= PC_C);
    assign link_clip  = (CW'(link) > PC_C) ? EMPTY : link;
    assign head_bytes = 48'(r_head) << PB_W;

    assign walk_frame = CW'(r_frame);
    assign walk_done  = (r_frame >= r_end);
    assign walk_rng   = !walk_done && (walk_frame >= PC_C);

    assign free_frame = CW'(r_page >> PB_W);

    always_comb begin
        if (r_page == 24'd0) begin
            free_status = ST_NULL;
        end else if (r_page[PB_W-1:0] != '0) begin
            free_status = ST_ALIGN;
        end else if (free_frame >= PC_C) begin
            free_status = ST_RANGE;
        end else begin
            free_status = ST_OK;
        end
    end

    assign free_push = i_cmd.finish && (r_kind == K_FREE) && (free_status == ST_OK);
    assign added_inc = 26'(r_added) + PB_26;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        res             = '0;
        res.total_bytes = r_added;
        case (r_kind)
            K_REGION: res.status = walk_rng ? ST_RANGE : ST_OK;
            K_END:    res.status = (r_added == 25'd0) ? ST_NOMEM : ST_OK;
            K_ALLOC: begin
                if (head_empty) begin
                    res.status = ST_NOMEM;
                end else begin
                    res.status     = ST_OK;
                    res.alloc_addr = head_bytes[23:0];
                end
            end
            K_FREE:   res.status = free_status;
            default:  res.status = ST_OK;
        endcase
    end

    fpsa_ram #(
        .WIDTH (HW),
        .DEPTH (PAGE_COUNT)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.walk_push || free_push),
        .i_wr_addr (i_cmd.walk_push ? walk_frame[FW-1:0] : free_frame[FW-1:0]),
        .i_wr_data (r_head),
        .i_rd_en   (i_cmd.load && !head_empty),
        .i_rd_addr (r_head[FW-1:0]),
        .o_rd_data (link)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= EMPTY;
            r_added     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.walk_push) begin
                r_head  <= walk_frame[HW-1:0];
                r_added <= (added_inc > TOT_MAX) ? TOT_MAX[24:0] : added_inc[24:0];
            end else if (free_push) begin
                r_head <= free_frame[HW-1:0];
            end else if (i_cmd.finish && (r_kind == K_ALLOC) && !head_empty) begin
                r_head <= link_clip;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and walk registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in_data.kind;
            r_page  <= i_in_data.page_addr;
            r_frame <= first_sum[25:PB_W];
            // A region that is not usable gets an empty walk.
            r_end   <= i_in_data.region_usable ? end_sum[25:PB_W] : first_sum[25:PB_W];
        end else if (i_cmd.walk_push) begin
            r_frame <= r_frame + FRW'(1);
        end
        if (i_cmd.finish) begin
            r_out <= res;
        end
    end

    assign o_stat.in_kind   = i_in_data.kind;
    assign o_stat.walk_stop = walk_done || walk_rng;
    assign o_stat.out_free  = out_free;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule
